// File: rtl/assert_macros.svh
// Assertion helpers; all checks run on clk and are held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");
`define ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, prop)
`define ASSERT_IMPLY(label, ante, cons)
`endif

`endif

// File: rtl/fxa_pkg.sv
package fxa_pkg;

	localparam int FRACTION_BITS = 8;
	// numerator width of the divider: |a| shifted up by the fraction bits
	localparam int NW = 32 + FRACTION_BITS;

	localparam logic [31:0] RAW_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] RAW_MIN = 32'h8000_0000;

	typedef enum logic [2:0] {
		OP_ADD   = 3'd0,
		OP_SUB   = 3'd1,
		OP_MUL   = 3'd2,
		OP_DIV   = 3'd3,
		OP_MIN   = 3'd4,
		OP_MAX   = 3'd5,
		OP_INC   = 3'd6,
		OP_TOINT = 3'd7
	} op_t;

	typedef struct packed {
		logic [2:0]         opcode;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} in_t;

	typedef struct packed {
		logic signed [31:0] result_raw;
		logic               a_less;
		logic               a_equal;
		logic               a_greater;
		logic               overflow;
		logic               divide_by_zero;
	} out_t;

	typedef struct packed {
		op_t             op;
		logic            neg;
		logic            lt;
		logic            eq;
		logic            gt;
		logic            ovf;
		logic            dz;
		logic [31:0]     res;
		logic [31:0]     dvsr;
		logic [NW-1:0]   num;
		logic [NW-1:0]   quo;
		logic [31:0]     rem;
	} pipe_t;

	typedef struct packed {
		logic        ovf;
		logic [31:0] val;
	} sat_t;

	// apply sign to an unsigned magnitude and clamp to the 32-bit range
	function automatic sat_t sat_mag(input logic [63:0] m, input logic neg);
		sat_t s;
		s.ovf = 1'b0;
		if (!neg) begin
			if (m > 64'h0000_0000_7FFF_FFFF) begin
				s.ovf = 1'b1;
				s.val = RAW_MAX;
			end else begin
				s.val = m[31:0];
			end
		end else begin
			if (m > 64'h0000_0000_8000_0000) begin
				s.ovf = 1'b1;
				s.val = RAW_MIN;
			end else begin
				s.val = ~m[31:0] + 32'd1;
			end
		end
		return s;
	endfunction

endpackage

// File: rtl/fixed_point_alu_q24_8_top.sv
// Signed Q24.8 fixed-point ALU, one request in and one response out per transaction.
// req carries opcode, operand_a and operand_b; rsp carries the saturated result,
// the a-versus-b compare flags, overflow and divide_by_zero.
// Both channels use valid/stall: a transaction moves on a rising edge with valid
// high and stall low.
// Every opcode passes through the same stages, so responses come back in
// request order. Throughput is one transaction per cycle unless rsp_stall holds a response.
// The depth is set by the divider, which resolves one quotient bit per stage
// over NW stages; the 32x32 multiplier sits in a single stage.
// Multiply and divide round exact halves away from zero.
// When rsp_stall holds a pending response, the whole pipeline freezes and
// req_stall rises in the same cycle; nothing is dropped or repeated.
// Reset clears every stage valid bit; rsp_valid is low until a request arrives.
`include "assert_macros.svh"

module fixed_point_alu_q24_8_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  fxa_pkg::in_t  req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output fxa_pkg::out_t rsp
);
	import fxa_pkg::*;

	logic          adv;
	logic          v_s1, v_s2, v_s3, v_s4, v_s6, v_s7;
	logic [NW-1:0] v_s5;
	in_t           in_s1;
	pipe_t         p_s2, p_s3, p_s4, p_s6;
	pipe_t         p_s5 [NW];
	pipe_t         nx2, nx4;
	logic [63:0]   prod_s2, mmag_s3;
	logic [NW:0]   qm_s6;
	out_t          out_s7, nx7;
	logic [31:0]   mag_a, mag_b;
	logic [32:0]   sum, dif;
	logic          rnd6;
	sat_t          mul_sat, div_sat;

	assign adv       = !(v_s7 && rsp_stall);
	assign req_stall = !adv;
	assign rsp_valid = v_s7;
	assign rsp       = out_s7;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s6 <= v_s5[NW-1];
			v_s7 <= v_s6;
		end
	end

	// stage 2: operand prep, simple ops, multiplier
	always_comb begin
		mag_a = in_s1.operand_a[31] ? (~in_s1.operand_a + 32'd1) : in_s1.operand_a;
		mag_b = in_s1.operand_b[31] ? (~in_s1.operand_b + 32'd1) : in_s1.operand_b;
		sum   = {in_s1.operand_a[31], in_s1.operand_a} + {in_s1.operand_b[31], in_s1.operand_b};
		dif   = {in_s1.operand_a[31], in_s1.operand_a} - {in_s1.operand_b[31], in_s1.operand_b};
		nx2      = '0;
		nx2.op   = op_t'(in_s1.opcode);
		nx2.neg  = in_s1.operand_a[31] ^ in_s1.operand_b[31];
		nx2.lt   = $signed(in_s1.operand_a) < $signed(in_s1.operand_b);
		nx2.eq   = in_s1.operand_a == in_s1.operand_b;
		nx2.gt   = $signed(in_s1.operand_a) > $signed(in_s1.operand_b);
		nx2.dvsr = mag_b;
		nx2.num  = {mag_a, {FRACTION_BITS{1'b0}}};
		case (op_t'(in_s1.opcode))
			OP_ADD: begin
				if (sum[32] != sum[31]) begin
					nx2.ovf = 1'b1;
					nx2.res = sum[32] ? RAW_MIN : RAW_MAX;
				end else begin
					nx2.res = sum[31:0];
				end
			end
			OP_SUB: begin
				if (dif[32] != dif[31]) begin
					nx2.ovf = 1'b1;
					nx2.res = dif[32] ? RAW_MIN : RAW_MAX;
				end else begin
					nx2.res = dif[31:0];
				end
			end
			OP_DIV: begin
				nx2.dz = in_s1.operand_b == 32'sd0;
			end
			OP_MIN: begin
				nx2.res = nx2.lt ? in_s1.operand_a : in_s1.operand_b;
			end
			OP_MAX: begin
				nx2.res = nx2.lt ? in_s1.operand_b : in_s1.operand_a;
			end
			OP_INC: begin
				if (in_s1.operand_a == RAW_MAX) begin
					nx2.ovf = 1'b1;
					nx2.res = RAW_MAX;
				end else begin
					nx2.res = in_s1.operand_a + 32'd1;
				end
			end
			OP_TOINT: begin
				nx2.res = 32'($signed(in_s1.operand_a) >>> FRACTION_BITS);
			end
			default: begin
			end
		endcase
	end

	// stage 4: multiply sign and clamp
	always_comb begin
		mul_sat = sat_mag(mmag_s3, p_s3.neg);
		nx4     = p_s3;
		if (p_s3.op == OP_MUL) begin
			nx4.res = mul_sat.val;
			nx4.ovf = mul_sat.ovf;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			in_s1   <= req;
			p_s2    <= nx2;
			prod_s2 <= 64'(mag_a) * 64'(mag_b);
			p_s3    <= p_s2;
			// half LSB of the product decides the round-up
			mmag_s3 <= (prod_s2 >> FRACTION_BITS) + 64'(prod_s2[FRACTION_BITS-1]);
			p_s4    <= nx4;
		end
	end

	// stage 5: restoring divider, one quotient bit per stage
	for (genvar k = 0; k < NW; k++) begin : g_step
		pipe_t       prv;
		pipe_t       nxt;
		logic        pv;
		logic [32:0] trial;
		logic        take;

		if (k == 0) begin : g_first
			assign prv = p_s4;
			assign pv  = v_s4;
		end else begin : g_next
			assign prv = p_s5[k-1];
			assign pv  = v_s5[k-1];
		end

		assign trial = {prv.rem, prv.num[NW-1]};
		assign take  = trial >= {1'b0, prv.dvsr};

		always_comb begin
			nxt     = prv;
			nxt.num = prv.num << 1;
			nxt.quo = {prv.quo[NW-2:0], take};
			if (take) begin
				nxt.rem = 32'(trial - {1'b0, prv.dvsr});
			end else begin
				// trial stays below the divisor, so its top bit is clear
				nxt.rem = trial[31:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s5[k] <= 1'b0;
			end else if (adv) begin
				v_s5[k] <= pv;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				p_s5[k] <= nxt;
			end
		end
	end

	// stage 6: round quotient (2*rem >= divisor), stage 7: sign, clamp, select
	assign rnd6 = {p_s5[NW-1].rem, 1'b0} >= {1'b0, p_s5[NW-1].dvsr};

	always_comb begin
		div_sat               = sat_mag(64'(qm_s6), p_s6.neg);
		nx7.result_raw        = p_s6.res;
		nx7.a_less            = p_s6.lt;
		nx7.a_equal           = p_s6.eq;
		nx7.a_greater         = p_s6.gt;
		nx7.overflow          = p_s6.ovf;
		nx7.divide_by_zero    = p_s6.dz;
		if (p_s6.op == OP_DIV) begin
			if (p_s6.dz) begin
				nx7.result_raw = '0;
				nx7.overflow   = 1'b0;
			end else begin
				nx7.result_raw = div_sat.val;
				nx7.overflow   = div_sat.ovf;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s6   <= p_s5[NW-1];
			qm_s6  <= {1'b0, p_s5[NW-1].quo} + (NW+1)'(rnd6);
			out_s7 <= nx7;
		end
	end

	`ASSERT_ALWAYS(a_cmp_onehot, !rsp_valid || $onehot({rsp.a_less, rsp.a_equal, rsp.a_greater}))
	`ASSERT_IMPLY(a_dz_zero, rsp_valid && rsp.divide_by_zero, rsp.result_raw == 32'sd0 && !rsp.overflow)
	`ASSERT_IMPLY(a_backpressure, rsp_valid && rsp_stall, req_stall)

endmodule
